// ===== sv/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer: the request
// kinds on the input stream and the fixed field widths of both streams.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    localparam int ACTION_W    = 2;
    localparam int SYMBOL_W    = 8;
    localparam int VALUE_W     = 32;
    localparam int LENGTH_W    = 6;
    localparam int IN_DATA_W   = 48;

    localparam int BYTE_BITS   = 8;
    localparam int PAD_W       = 3;
    localparam int OUT_DATA_W  = 16;

    // One table entry per byte symbol.
    localparam int TABLE_DEPTH = 256;
    // Widest code the table word can hold.
    localparam int TABLE_WORD_BITS = 32;

endpackage

`default_nettype wire

// ===== sv/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable that holds the last read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder for a byte alphabet: a code table in RAM and a bit
// accumulator that packs codes into bytes, most significant bit first.
// ----------------------------------------------------------------------------
// Usage:
// Input requests arrive on s_tvalid/s_tready; s_tuser gives the kind (load a
// table entry, encode a symbol, flush) and s_tdata the symbol, code bits and
// code length. Loads write the table in the cycle they are accepted and give
// no result. Each encode gives one result per completed byte, and a flush
// gives exactly one result with m_tlast high, carrying the padding count.
// A request that gives results passes the table-read stage and then the
// output register before its first result appears. It waits in the
// table-read stage, holding off further input, until the single-byte output
// register is empty or hands over its last byte; loads and encodes that
// complete no byte are taken at one request per cycle while none waits. The
// table RAM is read once per request at acceptance, and a load commits
// before any later read. After reset a clearing pass zeroes every table
// entry, during which s_tready stays low. When the receiver stalls, the
// current result holds on m_tdata and requests that give no result flow on.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: symbol[7:0], code_value[39:8], code_length[45:40], zeros[47:46]
    input  wire logic [47:0] s_tdata,
    // s_tuser: action[1:0]
    input  wire logic [1:0]  s_tuser,
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: out_byte[7:0], byte_valid[8], pad_bits[11:9], zeros[15:12]
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::TABLE_WORD_BITS) ?
                            MAX_CODE_LEN : hcbp_pkg::TABLE_WORD_BITS;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int RAM_W  = CODE_W + LEN_W;
    localparam int ADDR_W = $clog2(hcbp_pkg::TABLE_DEPTH);
    localparam int MAXB   = (CODE_W + hcbp_pkg::BYTE_BITS - 1) / hcbp_pkg::BYTE_BITS;
    localparam int CNT_W  = $clog2(MAXB + 1);
    localparam int ACC_W  = hcbp_pkg::BYTE_BITS * (MAXB + 1);
    localparam int TOT_W  = $clog2(CODE_W + hcbp_pkg::BYTE_BITS);
    localparam int PC_W   = $clog2(hcbp_pkg::BYTE_BITS);
    localparam int BB     = hcbp_pkg::BYTE_BITS;

    // Input field views.
    hcbp_pkg::action_t           in_action;
    logic [ADDR_W-1:0]           in_symbol;
    logic [CODE_W-1:0]           in_value;
    logic [hcbp_pkg::LENGTH_W-1:0] in_length;
    logic                        in_accept;

    assign in_action = hcbp_pkg::action_t'(s_tuser);
    assign in_symbol = s_tdata[ADDR_W-1:0];
    assign in_value  = s_tdata[hcbp_pkg::SYMBOL_W +: CODE_W];
    assign in_length = s_tdata[hcbp_pkg::SYMBOL_W + hcbp_pkg::VALUE_W +: hcbp_pkg::LENGTH_W];
    assign in_accept = s_tvalid && s_tready;

    // Registers.
    logic              clr_reg,       clr_next;
    logic [ADDR_W-1:0] clr_addr_reg,  clr_addr_next;
    logic              s1_valid_reg,  s1_valid_next;
    hcbp_pkg::action_t s1_act_reg,    s1_act_next;
    logic [BB-1:0]     pend_reg,      pend_next;
    logic [PC_W-1:0]   pend_cnt_reg,  pend_cnt_next;
    logic [CNT_W-1:0]  left_reg,      left_next;
    logic [ACC_W-1:0]  word_reg,      word_next;
    logic              last_reg,      last_next;
    logic              bvalid_reg,    bvalid_next;
    logic [hcbp_pkg::PAD_W-1:0] pad_reg, pad_next;

    // Load path: clamp the length and left-align the code in the table word,
    // which also clears the bits above the length.
    logic [LEN_W-1:0]  ld_len;
    logic [LEN_W-1:0]  ld_shift;
    logic [CODE_W-1:0] ld_code;

    always_comb
    begin
        if (in_length > hcbp_pkg::LENGTH_W'(CODE_W))
        begin
            ld_len = LEN_W'(CODE_W);
        end
        else
        begin
            ld_len = LEN_W'(in_length);
        end
        ld_shift = LEN_W'(CODE_W) - ld_len;
        ld_code  = in_value << ld_shift;
    end

    // Table RAM: the clearing pass owns the write port until it is done.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;

    assign ram_we    = clr_reg || (in_accept && (in_action == hcbp_pkg::ACT_LOAD));
    assign ram_waddr = clr_reg ? clr_addr_reg : in_symbol;
    assign ram_wdata = clr_reg ? '0 : {ld_code, ld_len};

    hcbp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (hcbp_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_symbol),
        .rdata (ram_rdata)
    );

    // Encode path: append the aligned code behind the pending bits.
    logic [LEN_W-1:0]  rd_len;
    logic [CODE_W-1:0] rd_code;
    logic [ACC_W-1:0]  enc_word;
    logic [TOT_W-1:0]  enc_total;
    logic [CNT_W-1:0]  enc_nbytes;
    logic [ACC_W-1:0]  enc_rest;

    always_comb
    begin
        rd_len     = ram_rdata[LEN_W-1:0];
        rd_code    = ram_rdata[RAM_W-1:LEN_W];
        enc_word   = {pend_reg, {(ACC_W-BB){1'b0}}}
                   | ({rd_code, {(ACC_W-CODE_W){1'b0}}} >> pend_cnt_reg);
        enc_total  = TOT_W'(pend_cnt_reg) + TOT_W'(rd_len);
        enc_nbytes = CNT_W'(enc_total >> PC_W);
        enc_rest   = enc_word << {enc_nbytes, {PC_W{1'b0}}};
    end

    // Stage hand-over: requests without output never wait for the emitter.
    logic produces;
    logic emit_free;
    logic s1_move;
    logic out_take;

    assign out_take  = m_tvalid && m_tready;
    assign produces  = s1_valid_reg &&
                       ((s1_act_reg == hcbp_pkg::ACT_FLUSH) ||
                        ((s1_act_reg == hcbp_pkg::ACT_ENCODE) && (enc_nbytes != '0)));
    assign emit_free = (left_reg == '0) || ((left_reg == CNT_W'(1)) && m_tready);
    assign s1_move   = s1_valid_reg && (!produces || emit_free);
    assign s_tready  = !clr_reg && (!s1_valid_reg || s1_move);

    // Next-state logic.
    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        s1_valid_next = s1_valid_reg;
        s1_act_next   = s1_act_reg;
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        left_next     = left_reg;
        word_next     = word_reg;
        last_next     = last_reg;
        bvalid_next   = bvalid_reg;
        pad_next      = pad_reg;

        // Clearing pass after reset.
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clr_next = 1'b0;
            end
        end

        // Table-read stage.
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_act_next   = in_action;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        // Output register: shift out the next byte once one is taken.
        if (out_take)
        begin
            left_next = left_reg - CNT_W'(1);
            word_next = word_reg << BB;
        end

        // Accumulator update and emitter load.
        if (s1_move)
        begin
            case (s1_act_reg)
                hcbp_pkg::ACT_ENCODE:
                begin
                    pend_next     = enc_rest[ACC_W-1 -: BB];
                    pend_cnt_next = enc_total[PC_W-1:0];
                    if (produces)
                    begin
                        left_next   = enc_nbytes;
                        word_next   = enc_word;
                        last_next   = 1'b0;
                        bvalid_next = 1'b1;
                        pad_next    = '0;
                    end
                end
                hcbp_pkg::ACT_FLUSH:
                begin
                    pend_next     = '0;
                    pend_cnt_next = '0;
                    left_next     = CNT_W'(1);
                    word_next     = {pend_reg, {(ACC_W-BB){1'b0}}};
                    last_next     = 1'b1;
                    bvalid_next   = (pend_cnt_reg != '0);
                    // Eight minus the count, and zero when nothing is pending.
                    pad_next      = hcbp_pkg::PAD_W'(BB - int'(pend_cnt_reg));
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
            left_reg     <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= s1_valid_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
            left_reg     <= left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_act_reg <= s1_act_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
        bvalid_reg <= bvalid_next;
        pad_reg    <= pad_next;
    end

    // Output stream.
    assign m_tvalid = (left_reg != '0);
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(hcbp_pkg::OUT_DATA_W - BB - 1 - hcbp_pkg::PAD_W){1'b0}},
                       pad_reg, bvalid_reg, word_reg[ACC_W-1 -: BB]};

`ifndef SYNTH
    // No request is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // With a pending count of zero, no pending bit is set.
    a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg == '0) |-> (pend_reg == '0))
        else $error("pending bits present with zero count");

    // A flush result is always the only byte of its request.
    a_flush_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (left_reg == CNT_W'(1)))
        else $error("flush result followed by further bytes");

    // The emitter never holds more bytes than one code can complete.
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= CNT_W'(MAXB))
        else $error("byte count beyond code limit");
`endif

endmodule

`default_nettype wire

// ===== tb/hcbp_packer_monitor.sv =====
// ----------------------------------------------------------------------------
// hcbp_packer_monitor
// Watches both streams of the Huffman code bit packer. Every accepted request
// goes through a local model of the code table and bit accumulator. The model
// queues the bytes that the request should release. Every accepted output
// request is checked, field by field, against the oldest byte still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer_monitor #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // s_tdata: symbol[7:0], code_value[39:8], code_length[45:40], zeros[47:46]
    input  wire logic [47:0] s_tdata,
    // s_tuser: action[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: out_byte[7:0], byte_valid[8], pad_bits[11:9], zeros[15:12]
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    output int unsigned      mismatches,
    output int unsigned      bytes_owed
);

    // Longest code that survives a load.
    localparam int CODE_LIMIT = (MAX_CODE_LEN < hcbp_pkg::TABLE_WORD_BITS) ?
                                MAX_CODE_LEN : hcbp_pkg::TABLE_WORD_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] pad_bits;
        logic       last;
    } packed_byte_t;

    // Local copy of the code table and the partial byte.
    logic [hcbp_pkg::TABLE_WORD_BITS-1:0] code_mem [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LENGTH_W-1:0]        len_mem  [hcbp_pkg::TABLE_DEPTH];
    logic [6:0]                           held_bits;
    logic [2:0]                           held_count;

    // Bytes predicted but not yet seen on the output stream.
    packed_byte_t bytes_due [$];

    function automatic packed_byte_t make_byte(input logic [7:0] value, input logic valid,
                                               input logic [2:0] pad, input logic last);
        packed_byte_t b;
        b.out_byte   = value;
        b.byte_valid = valid;
        b.pad_bits   = pad;
        b.last       = last;
        return b;
    endfunction

    // Add one byte to the end of the list of bytes owed.
    task automatic owe_byte(input packed_byte_t b);
        bytes_due = {bytes_due, b};
    endtask

    task automatic log_fault(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    // Apply one request to the local model and queue the bytes it releases.
    task automatic pack_request(input logic [1:0] act, input logic [47:0] data);
        logic [7:0]  sym;
        logic [31:0] value;
        int          len;
        int          total;
        logic [63:0] mask;
        logic [63:0] acc;
        logic [63:0] part;
        logic [15:0] padded;
        int          pad;
        sym   = data[7:0];
        value = data[39:8];
        len   = int'(data[45:40]);
        case (act)
            hcbp_pkg::ACT_LOAD:
            begin
                if (len > CODE_LIMIT)
                    len = CODE_LIMIT;
                mask          = (64'd1 << len) - 64'd1;
                code_mem[sym] = value & mask[31:0];
                len_mem[sym]  = hcbp_pkg::LENGTH_W'(len);
            end
            hcbp_pkg::ACT_ENCODE:
            begin
                len   = int'(len_mem[sym]);
                acc   = ({57'd0, held_bits} << len) | {32'd0, code_mem[sym]};
                total = int'(held_count) + len;
                while (total >= hcbp_pkg::BYTE_BITS)
                begin
                    part = acc >> (total - hcbp_pkg::BYTE_BITS);
                    owe_byte(make_byte(part[7:0], 1'b1, 3'd0, 1'b0));
                    total -= hcbp_pkg::BYTE_BITS;
                end
                mask       = (64'd1 << total) - 64'd1;
                acc        = acc & mask;
                held_bits  = acc[6:0];
                held_count = 3'(total);
            end
            hcbp_pkg::ACT_FLUSH:
            begin
                if (held_count == 3'd0)
                begin
                    owe_byte(make_byte(8'd0, 1'b0, 3'd0, 1'b1));
                end
                else
                begin
                    pad    = hcbp_pkg::BYTE_BITS - int'(held_count);
                    padded = {9'd0, held_bits} << pad;
                    owe_byte(make_byte(padded[7:0], 1'b1, 3'(pad), 1'b1));
                end
                held_bits  = 7'd0;
                held_count = 3'd0;
            end
            default:
            begin
                // The spare action code is ignored by the block.
            end
        endcase
    endtask

    // Sample both streams at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        packed_byte_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < hcbp_pkg::TABLE_DEPTH; i++)
            begin
                code_mem[i] = '0;
                len_mem[i]  = '0;
            end
            held_bits  = '0;
            held_count = '0;
            bytes_due.delete();
            mismatches = 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = make_byte(m_tdata[7:0], m_tdata[8], m_tdata[11:9], m_tlast);
                if (bytes_due.size() == 0)
                begin
                    log_fault($sformatf("unexpected byte %02h valid %0b pad %0d last %0b",
                                        got.out_byte, got.byte_valid, got.pad_bits,
                                        got.last));
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
                        || got.pad_bits !== want.pad_bits || got.last !== want.last)
                        log_fault($sformatf(
                            "expected byte %02h valid %0b pad %0d last %0b, got %02h %0b %0d %0b",
                            want.out_byte, want.byte_valid, want.pad_bits, want.last,
                            got.out_byte, got.byte_valid, got.pad_bits, got.last));
                end
            end
            if (s_tvalid && s_tready)
                pack_request(s_tuser, s_tdata);
            bytes_owed <= bytes_due.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/huffman_code_bit_packer_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_tb
// Stimulus for the Huffman code bit packer. A short directed part covers
// empty and oversized codes, the spare action, full 32-bit codes and flushes
// with and without pending bits. It is followed by a table load of the
// common symbols and a random mix of loads, encodes and flushes. Both sides
// idle in random bursts, except in a quiet stretch at the end. Checking is
// left to the monitor.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_tb;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RESET_CYCLES      = 8;
    localparam int RANDOM_REQUESTS   = 340;
    localparam int COMMON_SYMBOLS    = 32;
    localparam int QUIET_FROM        = 280;
    localparam int SETTLE_CYCLES     = 16;
    localparam int CYCLE_LIMIT       = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int unsigned mismatches;
    int unsigned bytes_owed;
    int unsigned cycle_count;
    bit          quiet;

    huffman_code_bit_packer #(
        .MAX_CODE_LEN (32)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    hcbp_packer_monitor #(
        .MAX_CODE_LEN (32)
    ) monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver back-pressure in random bursts, none in the quiet stretch.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Mostly the common symbols, so that encodes hit loaded entries.
    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, COMMON_SYMBOLS - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short codes, with empty, long and oversized lengths mixed in.
    function automatic logic [5:0] pick_length();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 6'd0;
        if (roll == 1)
            return 6'($urandom_range(33, 63));
        if (roll <= 3)
            return 6'($urandom_range(13, 32));
        return 6'($urandom_range(1, 12));
    endfunction

    // Offer a request, after an optional idle burst, until s_tready reads high.
    task automatic send_request(input logic [1:0] act, input logic [7:0] sym,
                                input logic [31:0] value, input logic [5:0] len);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, len, value, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted byte has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
    endtask

    // Reset, stimulus and verdict.
    initial
    begin
        int roll;
        quiet    = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty code and empty flush straight after reset.
        send_request(hcbp_pkg::ACT_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(hcbp_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0);
        // Full, empty, oversized, masked and all-zero codes.
        send_request(hcbp_pkg::ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_request(hcbp_pkg::ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
        send_request(hcbp_pkg::ACT_LOAD, 8'h5A, 32'hDEAD_BEEF, 6'd63);
        send_request(hcbp_pkg::ACT_LOAD, 8'h01, 32'hFFFF_FFFD, 6'd3);
        send_request(hcbp_pkg::ACT_LOAD, 8'h80, 32'h0000_0000, 6'd32);
        send_request(hcbp_pkg::ACT_LOAD, 8'hA5, 32'h1234_5678, 6'd33);
        send_request(hcbp_pkg::ACT_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_request(hcbp_pkg::ACT_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63);
        send_request(hcbp_pkg::ACT_ENCODE, 8'h5A, 32'h0, 6'd0);
        send_request(hcbp_pkg::ACT_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(ACT_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_request(hcbp_pkg::ACT_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_request(hcbp_pkg::ACT_ENCODE, 8'h80, 32'h0, 6'd0);
        send_request(hcbp_pkg::ACT_ENCODE, 8'hA5, 32'h0, 6'd0);
        // Seven single-bit codes leave seven bits for the flush.
        send_request(hcbp_pkg::ACT_LOAD, 8'h7F, 32'h0000_0001, 6'd1);
        for (int i = 0; i < 7; i++)
            send_request(hcbp_pkg::ACT_ENCODE, 8'h7F, 32'h0, 6'd0);
        send_request(hcbp_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0);

        // Random part: fill the common symbols first, then mix.
        for (int i = 0; i < COMMON_SYMBOLS; i++)
            send_request(hcbp_pkg::ACT_LOAD, 8'(i), $urandom, pick_length());
        for (int n = COMMON_SYMBOLS; n < RANDOM_REQUESTS; )
        begin
            if (n == RANDOM_REQUESTS / 2)
                wait_drained();
            if (n >= QUIET_FROM)
                quiet = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_request(ACT_SPARE, 8'($urandom), $urandom, 6'($urandom));
            end
            else
            begin
                if (roll < 22)
                    send_request(hcbp_pkg::ACT_LOAD, pick_symbol(), $urandom, pick_length());
                else if (roll < 30)
                    send_request(hcbp_pkg::ACT_FLUSH, 8'($urandom), $urandom, 6'($urandom));
                else
                    send_request(hcbp_pkg::ACT_ENCODE, pick_symbol(), $urandom,
                                 6'($urandom));
                n++;
            end
        end
        send_request(hcbp_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/hcbp_pkg.sv
sv/hcbp_ram.sv
sv/huffman_code_bit_packer.sv
tb/hcbp_packer_monitor.sv
tb/huffman_code_bit_packer_tb.sv
